// ----- rtl/core/ccrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrp_pkg
// Shared types, widths and the cheat-code letter table.
// ----------------------------------------------------------------------------
package ccrp_pkg;

    localparam int CODE_SLOTS_DEF = 3;
    localparam int SLOT_W         = 42;
    localparam int CFG_IDX_W      = 3;   // covers up to eight slots
    localparam int ADDR_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int IN_W           = 24;
    localparam int LETTERS        = 8;
    localparam int LETTER_W       = 5;
    localparam int NIB_W          = 4;

    localparam int BIT_EIGHT  = 40;
    localparam int BIT_ENABLE = 41;

    // Decoded code slot
    typedef struct packed {
        logic              valid;    // enabled and all used letters legal
        logic              eight;
        logic [ADDR_W-2:0] addr;     // bit 15 implied set
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] compare;
    } slot_dec_t;

    // Item moving down the pipe
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              patched;
    } item_t;

    typedef struct packed {
        logic             ok;
        logic [NIB_W-1:0] nib;
    } nib_t;

    // Letter index (A=0..Z=25) to nibble; letters outside the sixteen-letter code set fail
    function automatic nib_t letter_nibble(input logic [LETTER_W-1:0] letter);
        nib_t r;
        r.ok = 1'b1;
        unique case (letter)
            5'd0:    r.nib = 4'h0;   // A
            5'd4:    r.nib = 4'h8;   // E
            5'd6:    r.nib = 4'h4;   // G
            5'd8:    r.nib = 4'h5;   // I
            5'd10:   r.nib = 4'hC;   // K
            5'd11:   r.nib = 4'h3;   // L
            5'd13:   r.nib = 4'hF;   // N
            5'd14:   r.nib = 4'h9;   // O
            5'd15:   r.nib = 4'h1;   // P
            5'd18:   r.nib = 4'hD;   // S
            5'd19:   r.nib = 4'h6;   // T
            5'd20:   r.nib = 4'hB;   // U
            5'd21:   r.nib = 4'hE;   // V
            5'd23:   r.nib = 4'hA;   // X
            5'd24:   r.nib = 4'h7;   // Y
            5'd25:   r.nib = 4'h2;   // Z
            default:
            begin
                r.ok  = 1'b0;
                r.nib = 4'h0;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/cheat_code_rom_read_patcher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cheat_code_rom_read_patcher_unit
// Cheat-code patcher for ROM reads: decodes code slots and substitutes bytes.
// ----------------------------------------------------------------------------
// Accepts one ROM read transfer per clock while the output is not stalled, and
// returns one result per read. The pipe is an input register, then one pipeline
// stage per code slot applying that slot in order; the last slot stage is the
// output register. Stalls on the output back up through the stage chain without
// loss. Each slot register is decoded into a registered address/value/compare
// set, so a configuration write takes effect only after the slot register and
// then the decode one. Writes to an index at or beyond CODE_SLOTS are ignored.
module cheat_code_rom_read_patcher_unit
#(
    parameter int CODE_SLOTS = ccrp_pkg::CODE_SLOTS_DEF,
    localparam int OUT_BITS  = ccrp_pkg::BYTE_W + 1 + CODE_SLOTS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ccrp_pkg::IN_W-1:0]      s_tdata,   // read_address, rom_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_W-1:0]               m_tdata,   // patched_byte, was_patched,
                                                      // slots_valid, zero pad
    input  logic                           cfg_we,
    input  logic [ccrp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ccrp_pkg::SLOT_W-1:0]    cfg_wdata
);
    import ccrp_pkg::*;

    slot_dec_t         dec   [CODE_SLOTS];
    logic              vld   [CODE_SLOTS+1];
    logic              rdy   [CODE_SLOTS+1];
    item_t             item  [CODE_SLOTS+1];
    logic [CODE_SLOTS-1:0] slots_valid;

    logic  in_valid_reg;
    item_t in_item_reg;

    // input register
    assign s_tready = !in_valid_reg || rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.addr    <= s_tdata[ADDR_W-1:0];
            in_item_reg.data    <= s_tdata[ADDR_W +: BYTE_W];
            in_item_reg.patched <= 1'b0;
        end
    end

    assign vld[0]  = in_valid_reg;
    assign item[0] = in_item_reg;

    for (genvar s = 0; s < CODE_SLOTS; s++)
    begin : g_slot
        logic slot_we;

        assign slot_we = cfg_we &&
                         ({1'b0, cfg_index} == (CFG_IDX_W+1)'(s));

        ccrp_slot_unit u_slot
        (
            .clk   (clk),
            .rst_n (rst_n),
            .we    (slot_we),
            .wdata (cfg_wdata),
            .dec   (dec[s])
        );

        ccrp_apply_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .dec       (dec[s]),
            .in_valid  (vld[s]),
            .in_ready  (rdy[s]),
            .in_item   (item[s]),
            .out_valid (vld[s+1]),
            .out_ready (rdy[s+1]),
            .out_item  (item[s+1])
        );

        assign slots_valid[s] = dec[s].valid;
    end

    assign rdy[CODE_SLOTS] = m_tready;
    assign m_tvalid        = vld[CODE_SLOTS];

    always_comb
    begin
        m_tdata                      = '0;
        m_tdata[BYTE_W-1:0]          = item[CODE_SLOTS].data;
        m_tdata[BYTE_W]              = item[CODE_SLOTS].patched;
        m_tdata[BYTE_W+1 +: CODE_SLOTS] = slots_valid;
    end

endmodule

// ----- rtl/core/ccrp_slot_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrp_slot_unit
// One code slot register and its registered decode (address/value/compare).
// ----------------------------------------------------------------------------
module ccrp_slot_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      we,
    input  logic [ccrp_pkg::SLOT_W-1:0] wdata,
    output ccrp_pkg::slot_dec_t       dec
);
    import ccrp_pkg::*;

    logic [SLOT_W-1:0] slot_reg;
    slot_dec_t         dec_reg;
    slot_dec_t         dec_next;
    nib_t              n [LETTERS];
    logic              letters_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            dec_reg  <= '0;
        end
        else
        begin
            if (we)
            begin
                slot_reg <= wdata;
            end
            dec_reg <= dec_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < LETTERS; i++)
        begin
            n[i] = letter_nibble(slot_reg[LETTER_W*i +: LETTER_W]);
        end
        letters_ok = n[0].ok & n[1].ok & n[2].ok & n[3].ok & n[4].ok & n[5].ok;
        if (slot_reg[BIT_EIGHT])
        begin
            letters_ok = letters_ok & n[6].ok & n[7].ok;
        end

        dec_next.valid = slot_reg[BIT_ENABLE] & letters_ok;
        dec_next.eight = slot_reg[BIT_EIGHT];
        // fixed bit shuffle of the code format
        dec_next.addr  = {n[3].nib[2:0], n[4].nib[3], n[5].nib[2:0], n[1].nib[3],
                          n[2].nib[2:0], n[3].nib[3], n[4].nib[2:0]};
        dec_next.value = {n[0].nib[3], n[1].nib[2:0],
                          (slot_reg[BIT_EIGHT] ? n[7].nib[3] : n[5].nib[3]),
                          n[0].nib[2:0]};
        dec_next.compare = slot_reg[BIT_EIGHT] ?
                           {n[6].nib[3], n[7].nib[2:0], n[5].nib[3], n[6].nib[2:0]} :
                           '0;
    end

    assign dec = dec_reg;

endmodule

// ----- rtl/core/ccrp_apply_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrp_apply_stage
// Pipeline stage that applies one decoded slot to the item passing through.
// ----------------------------------------------------------------------------
module ccrp_apply_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  ccrp_pkg::slot_dec_t dec,
    input  logic                in_valid,
    output logic                in_ready,
    input  ccrp_pkg::item_t     in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ccrp_pkg::item_t     out_item
);
    import ccrp_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic  hit;

    // slot address always has bit 15 set
    always_comb
    begin
        hit = dec.valid && in_item.addr[ADDR_W-1] &&
              (in_item.addr[ADDR_W-2:0] == dec.addr) &&
              (!dec.eight || (dec.compare == in_item.data));
        item_next = in_item;
        if (hit)
        begin
            item_next.data    = dec.value;
            item_next.patched = 1'b1;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- rtl/core/ccrp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrp_checker
// Port-level assertions for the cheat-code patcher, bound to the top level.
// ----------------------------------------------------------------------------
module ccrp_checker
#(
    parameter int CODE_SLOTS = ccrp_pkg::CODE_SLOTS_DEF,
    localparam int OUT_BITS  = ccrp_pkg::BYTE_W + 1 + CODE_SLOTS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [OUT_W-1:0]               m_tdata,
    input logic                           cfg_we
);
    import ccrp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transfer changed while stalled");

    // pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    // a free-running sink never backs up the input
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // no patch reported unless some slot is valid or cfg_we was recently high
    a_patch_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[BYTE_W] |-> (m_tdata[BYTE_W+1 +: CODE_SLOTS] != '0) ||
            $past(cfg_we) || $past(cfg_we, 2))
        else $error("patch reported with no valid slot");

endmodule

bind cheat_code_rom_read_patcher_unit ccrp_checker #(.CODE_SLOTS(CODE_SLOTS)) u_ccrp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we)
);
